FILE: sv/nts_pkg.sv
// Shared types and constants for the nearest timestamp matcher.
// No dependencies; imported by every module of the block.
package nts_pkg;

    // Field widths
    localparam int STAMP_W   = 63;
    localparam int HANDLE_W  = 16;
    localparam int TOL_W     = 30;
    localparam int MARGIN_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int TM_W      = MARGIN_W + 1;

    // Default ring size
    localparam int NTS_RING_DEPTH = 256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 2'd1;

    // Register reset values
    localparam logic [TOL_W-1:0]    TOL_RESET    = 30'd5000000;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd1000000000;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_PR_RD,
        ST_PR_CHK
    } nts_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic push;
        logic q_start;
        logic scan;
        logic load_out;
        logic pr_read;
        logic pr_pop;
    } nts_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic match_ok;
        logic prune_hit;
        logic out_busy;
    } nts_status_t;

endpackage

FILE: sv/nts_ctrl.sv
// Controller state machine of the nearest timestamp matcher.
// Depends on nts_pkg for the state type and the command/status structs.
module nts_ctrl
    import nts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        mode,
    output logic        in_stall,
    input  nts_status_t status,
    output nts_cmd_t    cmd
);

    nts_state_t state_reg;
    nts_state_t state_next;
    logic       accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free, prune only after a match
                if (!status.out_busy)
                begin
                    state_next = status.match_ok ? ST_PR_RD : ST_IDLE;
                end
            end
            ST_PR_RD:
            begin
                state_next = status.count_zero ? ST_IDLE : ST_PR_CHK;
            end
            ST_PR_CHK:
            begin
                state_next = status.prune_hit ? ST_PR_RD : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.push    = accept && !mode;
                cmd.q_start = accept && mode;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = !status.out_busy;
            end
            ST_PR_RD:
            begin
                cmd.pr_read = !status.count_zero;
            end
            ST_PR_CHK:
            begin
                cmd.pr_pop = status.prune_hit;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/nts_dpath.sv
// Datapath of the nearest timestamp matcher: ring memory, pointers, scan
// pipeline, configuration and output registers. Depends on nts_pkg.
module nts_dpath
    import nts_pkg::*;
#(
    parameter int RING_DEPTH = NTS_RING_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nts_cmd_t             cmd,
    output nts_status_t          status,
    input  logic [STAMP_W-1:0]   stamp_ns,
    input  logic [HANDLE_W-1:0]  sample_handle,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 matched,
    output logic [HANDLE_W-1:0]  match_handle,
    output logic [STAMP_W-1:0]   match_delta_ns
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WORD_W = STAMP_W + HANDLE_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(RING_DEPTH);

    // Ring memory: stamp in the upper bits, handle in the lower bits
    logic [WORD_W-1:0] mem [RING_DEPTH];
    logic [WORD_W-1:0] mem_q_reg;
    logic [PTR_W-1:0]  rd_addr;
    logic [PTR_W-1:0]  wr_addr;

    logic [PTR_W-1:0]  oldest_reg,  oldest_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [PTR_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic [CNT_W-1:0]  left_reg,    left_next;

    logic [TOL_W-1:0]    tol_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [TM_W-1:0]     tm_reg;
    logic [STAMP_W-1:0]  q_stamp_reg;
    logic [STAMP_W:0]    lim_reg;

    logic                rv1_reg;
    logic                rv2_reg;
    logic [STAMP_W-1:0]  delta2_reg;
    logic [HANDLE_W-1:0] handle2_reg;
    logic                found_reg;
    logic [STAMP_W-1:0]  best_delta_reg;
    logic [HANDLE_W-1:0] best_handle_reg;

    logic                out_valid_reg;
    logic                matched_reg;
    logic [HANDLE_W-1:0] match_handle_reg;
    logic [STAMP_W-1:0]  match_delta_reg;

    logic                full;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    tail_wrap;
    logic                scan_issue;
    logic [STAMP_W-1:0]  mem_stamp;
    logic [HANDLE_W-1:0] mem_handle;
    logic [STAMP_W:0]    diff_pos;
    logic [STAMP_W:0]    diff_neg;
    logic                best_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Write slot for a push
    assign full      = (count_reg == CNT_FULL);
    assign tail_sum  = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_DEPTH) ? tail_sum - SUM_DEPTH : tail_sum;
    assign wr_addr   = full ? oldest_reg : tail_wrap[PTR_W-1:0];

    assign scan_issue = cmd.scan && (left_reg != '0);
    assign rd_addr    = cmd.pr_read ? oldest_reg : rd_ptr_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= {stamp_ns, sample_handle};
        end
        mem_q_reg <= mem[rd_addr];
    end

    assign mem_stamp  = mem_q_reg[WORD_W-1:HANDLE_W];
    assign mem_handle = mem_q_reg[HANDLE_W-1:0];

    // Ring pointers and scan counters
    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        left_next   = left_reg;
        if (cmd.push)
        begin
            if (full)
            begin
                oldest_next = ptr_inc(oldest_reg);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.pr_pop)
        begin
            oldest_next = ptr_inc(oldest_reg);
            count_next  = count_reg - CNT_W'(1);
        end
        if (cmd.q_start)
        begin
            rd_ptr_next = oldest_reg;
            left_next   = count_reg;
        end
        else if (scan_issue)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            left_next   = left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            left_reg   <= '0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            left_reg   <= left_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOLERANCE: tol_reg    <= cfg_data[TOL_W-1:0];
                CFG_MARGIN:    margin_reg <= cfg_data[MARGIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Prune bound: query stamp minus tolerance and margin, sign bit marks underflow
    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            q_stamp_reg <= stamp_ns;
        end
        tm_reg  <= TM_W'(tol_reg) + TM_W'(margin_reg);
        lim_reg <= {1'b0, q_stamp_reg} - (STAMP_W + 1)'(tm_reg);
    end

    // Absolute difference stage
    assign diff_pos = {1'b0, mem_stamp} - {1'b0, q_stamp_reg};
    assign diff_neg = {1'b0, q_stamp_reg} - {1'b0, mem_stamp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv1_reg <= 1'b0;
            rv2_reg <= 1'b0;
        end
        else
        begin
            rv1_reg <= scan_issue;
            rv2_reg <= rv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        delta2_reg  <= diff_pos[STAMP_W] ? diff_neg[STAMP_W-1:0] : diff_pos[STAMP_W-1:0];
        handle2_reg <= mem_handle;
    end

    // Keep the nearest entry; strict less-than lets the earlier entry win a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.q_start)
        begin
            found_reg <= 1'b0;
        end
        else if (rv2_reg)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rv2_reg && (!found_reg || (delta2_reg < best_delta_reg)))
        begin
            best_delta_reg  <= delta2_reg;
            best_handle_reg <= handle2_reg;
        end
    end

    assign best_ok = found_reg && (best_delta_reg <= STAMP_W'(tol_reg));

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            matched_reg      <= best_ok;
            match_handle_reg <= best_ok ? best_handle_reg : '0;
            match_delta_reg  <= best_ok ? best_delta_reg : '0;
        end
    end

    // Status to the controller
    always_comb
    begin
        status.count_zero = (count_reg == '0);
        status.scan_done  = (left_reg == '0) && !rv1_reg && !rv2_reg;
        status.out_busy   = out_valid_reg && out_stall;
        status.match_ok   = best_ok;
        // Flag a front entry older than the prune bound
        status.prune_hit  = !lim_reg[STAMP_W] && ({1'b0, mem_stamp} < lim_reg);
    end

    assign out_valid      = out_valid_reg;
    assign matched        = matched_reg;
    assign match_handle   = match_handle_reg;
    assign match_delta_ns = match_delta_reg;

endmodule

FILE: sv/nearest_timestamp_matcher.sv
// Nearest timestamp matcher: a push word (mode 0) stores a stamp and handle in a
// ring of RING_DEPTH entries; a query word (mode 1) scans the ring from the oldest
// entry through one memory read port, one entry per cycle, then waits for the
// previous result to leave the output register and, after a match, prunes entries
// older than the prune bound from the front of the ring.
// One word is worked on at a time; a result waits in the output register while
// the next word is taken in.
// Top level; depends on nts_pkg, nts_ctrl and nts_dpath.
module nearest_timestamp_matcher
    import nts_pkg::*;
#(
    parameter int RING_DEPTH = NTS_RING_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic [STAMP_W-1:0]   stamp_ns,
    input  logic [HANDLE_W-1:0]  sample_handle,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 matched,
    output logic [HANDLE_W-1:0]  match_handle,
    output logic [STAMP_W-1:0]   match_delta_ns,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    nts_cmd_t    cmd;
    nts_status_t status;

    // Sequence push, scan and prune
    nts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Ring storage and compare logic
    nts_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .stamp_ns       (stamp_ns),
        .sample_handle  (sample_handle),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .matched        (matched),
        .match_handle   (match_handle),
        .match_delta_ns (match_delta_ns)
    );

endmodule

FILE: test/nts_tb_pkg.sv
// Word and register codes shared by the nearest timestamp matcher testbench.
// Depends on nts_pkg for the register index width.
`timescale 1ns / 1ps
package nts_tb_pkg;

    import nts_pkg::*;

    // Meaning of the mode field
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

endpackage

FILE: test/nts_match_checker.sv
// Checker for the nearest timestamp matcher: keeps its own copy of the sample ring
// and registers, predicts each query's match and compares the result words.
// Depends on nts_pkg and nts_tb_pkg.
`timescale 1ns / 1ps
module nts_match_checker
    import nts_pkg::*;
    import nts_tb_pkg::*;
#(
    parameter int RING_DEPTH = NTS_RING_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 mode,
    input  logic [STAMP_W-1:0]   stamp_ns,
    input  logic [HANDLE_W-1:0]  sample_handle,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 matched,
    input  logic [HANDLE_W-1:0]  match_handle,
    input  logic [STAMP_W-1:0]   match_delta_ns,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   pending_words,
    output int                   fail_count
);

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  delta;
    } match_word_t;

    // Model ring, oldest slot and fill level
    logic [STAMP_W-1:0]  ring_stamp  [RING_DEPTH];
    logic [HANDLE_W-1:0] ring_handle [RING_DEPTH];
    int                  oldest;
    int                  fill;

    // Model registers
    logic [TOL_W-1:0]    tol;
    logic [MARGIN_W-1:0] margin;

    match_word_t         match_q [$];
    match_word_t         want;

    function automatic int slot_at(int offset);
        return (oldest + offset) % RING_DEPTH;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, exp_val);
        fail_count++;
    endtask

    // Append a sample; drop the oldest one when the ring is full
    task automatic store_sample(logic [STAMP_W-1:0] stamp, logic [HANDLE_W-1:0] handle);
        int s;
        if (fill >= RING_DEPTH)
        begin
            ring_stamp[oldest]  = stamp;
            ring_handle[oldest] = handle;
            oldest = slot_at(1);
        end
        else
        begin
            s = slot_at(fill);
            ring_stamp[s]  = stamp;
            ring_handle[s] = handle;
            fill++;
        end
    endtask

    // Find the nearest sample, queue the result word, prune old samples after a match
    task automatic predict_match(logic [STAMP_W-1:0] stamp);
        match_word_t          res;
        logic                 found;
        logic [STAMP_W-1:0]   best;
        logic [STAMP_W-1:0]   d;
        logic [STAMP_W-1:0]   e;
        logic [HANDLE_W-1:0]  best_h;
        logic [STAMP_W+1:0]   aged;
        int                   i;
        found  = 1'b0;
        best   = '0;
        best_h = '0;
        for (i = 0; i < fill; i++)
        begin
            e = ring_stamp[slot_at(i)];
            d = (e >= stamp) ? e - stamp : stamp - e;
            if (!found || d < best)
            begin
                found  = 1'b1;
                best   = d;
                best_h = ring_handle[slot_at(i)];
                if (d == '0)
                    break;
            end
        end
        if (found && best <= tol)
        begin
            res = '{hit: 1'b1, handle: best_h, delta: best};
            // Drop front samples older than stamp - tolerance - margin, without wrap
            while (fill > 0)
            begin
                aged = ring_stamp[oldest] + tol + margin;
                if (aged < {2'b00, stamp})
                begin
                    oldest = slot_at(1);
                    fill--;
                end
                else
                    break;
            end
        end
        else
            res = '0;
        match_q.insert(match_q.size(), res);
    endtask

    // Check result words, track register writes, predict accepted input words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest = 0;
            fill   = 0;
            tol    = TOL_RESET;
            margin = MARGIN_RESET;
            match_q.delete();
            pending_words <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (match_q.size() == 0)
                    report_mismatch("result word with none expected", match_handle, 0);
                else
                begin
                    want = match_q[0];
                    match_q.delete(0);
                    if (matched !== want.hit)
                        report_mismatch("matched", matched, want.hit);
                    if (match_handle !== want.handle)
                        report_mismatch("match_handle", match_handle, want.handle);
                    if (match_delta_ns !== want.delta)
                        report_mismatch("match_delta_ns", match_delta_ns, want.delta);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOLERANCE)
                    tol = cfg_data[TOL_W-1:0];
                else if (cfg_index == CFG_MARGIN)
                    margin = cfg_data[MARGIN_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_PUSH)
                    store_sample(stamp_ns, sample_handle);
                else
                    predict_match(stamp_ns);
            end
            pending_words <= match_q.size();
        end
    end

endmodule

FILE: test/testbench.sv
// Top of the nearest timestamp matcher testbench: clock, reset, stimulus and verdict.
// Depends on nts_pkg, nts_tb_pkg, nts_match_checker and the nearest_timestamp_matcher RTL.
`timescale 1ns / 1ps
module testbench;

    import nts_pkg::*;
    import nts_tb_pkg::*;

    localparam int     PHASE_WORDS = 470;
    localparam int     TAIL_CYCLES = 2 * NTS_RING_DEPTH + 64;
    localparam longint LIMIT_NS    = 200_000_000;

    typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY} stall_kind_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 mode          = MODE_PUSH;
    logic [STAMP_W-1:0]   stamp_ns      = '0;
    logic [HANDLE_W-1:0]  sample_handle = '0;
    logic                 out_stall     = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_TOLERANCE;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 matched;
    logic [HANDLE_W-1:0]  match_handle;
    logic [STAMP_W-1:0]   match_delta_ns;
    int                   pending_words;
    int                   fail_count;

    // Stimulus state: sensor time base, recent sample stamps, current tolerance
    logic [STAMP_W-1:0]   sim_clock;
    logic [STAMP_W-1:0]   recent_q [$];
    int unsigned          tol_now;
    int                   burst_left;

    nearest_timestamp_matcher #(.RING_DEPTH(NTS_RING_DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .stamp_ns       (stamp_ns),
        .sample_handle  (sample_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .matched        (matched),
        .match_handle   (match_handle),
        .match_delta_ns (match_delta_ns),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    nts_match_checker #(.RING_DEPTH(NTS_RING_DEPTH)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .stamp_ns       (stamp_ns),
        .sample_handle  (sample_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .matched        (matched),
        .match_handle   (match_handle),
        .match_delta_ns (match_delta_ns),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending_words  (pending_words),
        .fail_count     (fail_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Send one input word; idle between bursts first
    task automatic send_word(logic m, logic [STAMP_W-1:0] s, logic [HANDLE_W-1:0] h);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        mode          <= m;
        stamp_ns      <= s;
        sample_handle <= h;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait until every result word is in, then let a trailing prune finish
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Empty ring, ties, exact hits, tolerance edge, no match, pruning, field extremes
    task automatic directed_words();
        send_word(MODE_QUERY, '0, 16'hFFFF);
        send_word(MODE_PUSH, '0, 16'h0000);
        send_word(MODE_PUSH, 63'd1000, 16'hFFFF);
        send_word(MODE_PUSH, 63'd1000, 16'h1234);
        send_word(MODE_QUERY, 63'd1000, 16'h0000);
        send_word(MODE_QUERY, 63'd500, 16'h0000);
        send_word(MODE_QUERY, 63'd5_001_000, 16'h0000);
        send_word(MODE_QUERY, 63'd5_001_001, 16'h0000);
        send_word(MODE_PUSH, {STAMP_W{1'b1}}, 16'hA5A5);
        send_word(MODE_QUERY, {STAMP_W{1'b1}}, 16'h0000);
        send_word(MODE_QUERY, '0, 16'h0000);
        send_word(MODE_PUSH, 63'h2AAA_AAAA_AAAA_AAAA, 16'h5A5A);
        send_word(MODE_PUSH, 63'h5555_5555_5555_5555, 16'hC3C3);
        send_word(MODE_QUERY, 63'h5555_5555_5555_5558, 16'h0000);
        send_word(MODE_QUERY, 63'h2AAA_AAAA_AAAA_AAAA - 63'd5_000_000, 16'h0000);
        send_word(MODE_PUSH, 63'd1, 16'h0001);
        send_word(MODE_QUERY, 63'd2, 16'hFFFF);
    endtask

    // Mostly in-order sample streams with nearby queries, plus some noise
    task automatic random_words(int count);
        int                 n;
        int                 pick;
        int                 k;
        int unsigned        off;
        logic [STAMP_W-1:0] ref_stamp;
        logic [STAMP_W-1:0] s;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_word(1'($urandom), 63'({$urandom, $urandom}), 16'($urandom));
            else if (pick < 8)
                send_word(MODE_PUSH, sim_clock - $urandom, 16'($urandom));
            else if (pick < 33 && recent_q.size() > 0)
            begin
                ref_stamp = recent_q[$urandom_range(0, recent_q.size() - 1)];
                k = $urandom_range(0, 5);
                case (k)
                    0:       off = 0;
                    1:       off = tol_now;
                    2:       off = $urandom_range(0, tol_now);
                    3:       off = tol_now + 1;
                    default: off = $urandom_range(0, 3 * tol_now + 1000);
                endcase
                s = $urandom_range(0, 1) ? ref_stamp + off : ref_stamp - off;
                send_word(MODE_QUERY, s, 16'($urandom));
            end
            else
            begin
                // Advance sensor time: a few ms, now and then a long dropout
                sim_clock += $urandom_range(1_000_000, 10_000_000);
                if ($urandom_range(0, 49) == 0)
                    sim_clock += $urandom_range(0, 32'd3_000_000_000);
                recent_q.insert(recent_q.size(), sim_clock);
                if (recent_q.size() > 16)
                    recent_q.delete(0);
                send_word(MODE_PUSH, sim_clock, 16'($urandom));
            end
        end
    endtask

    // Receiver stall pattern
    initial
    begin
        stall_kind_t kind;
        forever
        begin
            kind = stall_kind_t'($urandom_range(0, 2));
            repeat ($urandom_range(50, 400))
            begin
                @(posedge clk);
                case (kind)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_COIN:  out_stall <= 1'($urandom);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
                    default:     out_stall <= 1'b0;
                endcase
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Stimulus phases over several register settings
    initial
    begin
        int unsigned t;
        burst_left = 0;
        tol_now    = TOL_RESET;
        sim_clock  = {2'b01, 29'($urandom), $urandom};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        random_words(PHASE_WORDS);
        drain();

        // Zero tolerance (high data bits set, then masked), no prune margin
        write_reg(CFG_TOLERANCE, 32'hC000_0000);
        write_reg(CFG_MARGIN, 32'h0000_0000);
        tol_now = 0;
        random_words(PHASE_WORDS);
        drain();

        // Largest settings; spare indexes must be ignored
        write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(CFG_MARGIN, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        tol_now = {TOL_W{1'b1}};
        random_words(PHASE_WORDS);
        drain();

        // Random settings
        t = $urandom_range(0, 20_000_000);
        write_reg(CFG_TOLERANCE, ($urandom & 32'hC000_0000) | t);
        write_reg(CFG_MARGIN, $urandom_range(0, 2_000_000_000));
        tol_now = t;
        random_words(PHASE_WORDS);
        drain();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: nearest_timestamp_matcher.f
sv/nts_pkg.sv
sv/nts_ctrl.sv
sv/nts_dpath.sv
sv/nearest_timestamp_matcher.sv
test/nts_tb_pkg.sv
test/nts_match_checker.sv
test/testbench.sv
